// ===== rtl/voice_activity_segment_smoother_macros.svh =====
// Assertion macros used by the checker file vass_checker.sv.
`ifndef VOICE_ACTIVITY_SEGMENT_SMOOTHER_MACROS_SVH
`define VOICE_ACTIVITY_SEGMENT_SMOOTHER_MACROS_SVH

// Check an expression at every clock edge outside reset.
`define VASS_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("voice activity smoother: check failed");

// Check that a condition is followed by another in the next cycle.
`define VASS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("voice activity smoother: sequence check failed");

`endif

// ===== rtl/vass_pkg.sv =====
// Package: shared types and constants of the voice activity segment smoother.
package vass_pkg;

    localparam int FIELD_W              = 24;
    localparam int CFG_W                = 10;
    localparam int CFG_IDX_W            = 2;
    localparam int FRAME_INDEX_BITS_DEF = 24;
    localparam int QUEUE_DEPTH          = 4;

    localparam logic [FIELD_W-1:0] FIELD_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_GAP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN = 2'd1;

    localparam logic [CFG_W-1:0] MAX_GAP_RESET = 10'd5;
    localparam logic [CFG_W-1:0] MIN_LEN_RESET = 10'd6;

    localparam logic KIND_RECORD  = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic {
        PH_FIRST,
        PH_SECOND
    } t_phase;

    typedef struct packed {
        logic               rec_ok;
        logic               sum_ok;
        logic [FIELD_W-1:0] seg_start;
        logic [FIELD_W-1:0] seg_end;
        logic [FIELD_W-1:0] speech_segments;
        logic [FIELD_W-1:0] silence_segments;
        logic [FIELD_W-1:0] speech_frames;
        logic [FIELD_W-1:0] total_frames;
    } t_entry;

endpackage

// ===== rtl/vass_front.sv =====
// Front end: configuration, segment tracking and per-frame result building.
module vass_front #(
    parameter int FRAME_INDEX_BITS = vass_pkg::FRAME_INDEX_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_frame_active,
    input  logic                           i_final_frame,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [vass_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [vass_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_full,
    output logic                           o_push,
    output vass_pkg::t_entry               o_entry
);

    localparam int FIB   = FRAME_INDEX_BITS;
    localparam int SUM_W = ((FIB > vass_pkg::FIELD_W) ? FIB : vass_pkg::FIELD_W) + 1;
    localparam logic [FIB-1:0] FRAME_MAX = '1;

    function automatic logic [vass_pkg::FIELD_W-1:0] sat_inc(
        input logic [vass_pkg::FIELD_W-1:0] x
    );
        return (x == vass_pkg::FIELD_MAX) ? x : x + 1'b1;
    endfunction

    logic [vass_pkg::CFG_W-1:0]   r_max_gap, r_min_len;
    logic                         r_in_seg, n_in_seg;
    logic                         r_any, n_any;
    logic [FIB-1:0]               r_start, n_start;
    logic [FIB-1:0]               r_end, n_end;
    logic [FIB-1:0]               r_frame, n_frame;
    logic [vass_pkg::FIELD_W-1:0] r_kept, n_kept;
    logic [vass_pkg::FIELD_W-1:0] r_sil, n_sil;
    logic [vass_pkg::FIELD_W-1:0] r_speech, n_speech;

    logic                         accept;
    logic [FIB-1:0]               nxt, seg_start_c, seg_end_c, dur;
    logic [FIB:0]                 gap;
    logic                         cand_open, gap_close, final_close, do_close, keep;
    logic                         any1, trailing;
    logic [SUM_W-1:0]             speech_sum;
    logic [vass_pkg::FIELD_W-1:0] speech_sat, kept1, sil1, speech1, sil_sum;

    assign o_ready     = !i_full;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_valid && !i_full;

    always_comb begin
        nxt         = (r_frame == FRAME_MAX) ? r_frame : r_frame + 1'b1;
        cand_open   = i_frame_active || r_in_seg;
        seg_start_c = (i_frame_active && !r_in_seg) ? r_frame : r_start;
        seg_end_c   = i_frame_active ? nxt : r_end;
        gap         = ({1'b0, r_frame} + (FIB+1)'(1)) - {1'b0, r_end};
        gap_close   = !i_frame_active && r_in_seg && (gap > (FIB+1)'(r_max_gap));
        final_close = i_final_frame && cand_open && !gap_close;
        do_close    = gap_close || final_close;
        dur         = seg_end_c - seg_start_c;
        keep        = do_close && (dur >= FIB'(r_min_len));
        speech_sum  = SUM_W'(r_speech) + SUM_W'(dur);
        speech_sat  = (speech_sum > SUM_W'(vass_pkg::FIELD_MAX)) ? vass_pkg::FIELD_MAX
                                                               : speech_sum[vass_pkg::FIELD_W-1:0];
        sil1        = (keep && (r_any || (seg_start_c != '0))) ? sat_inc(r_sil) : r_sil;
        kept1       = keep ? sat_inc(r_kept) : r_kept;
        speech1     = keep ? speech_sat : r_speech;
        any1        = r_any || keep;
        trailing    = (final_close && keep) ? (seg_end_c < nxt) : any1;
        if (!any1) begin
            sil_sum = vass_pkg::FIELD_W'(1);
        end else if (trailing) begin
            sil_sum = sat_inc(sil1);
        end else begin
            sil_sum = sil1;
        end
    end

    always_comb begin
        o_push                   = accept && (keep || i_final_frame);
        o_entry.rec_ok           = keep;
        o_entry.sum_ok           = i_final_frame;
        o_entry.seg_start        = vass_pkg::FIELD_W'(seg_start_c);
        o_entry.seg_end          = vass_pkg::FIELD_W'(seg_end_c);
        o_entry.speech_segments  = kept1;
        o_entry.silence_segments = sil_sum;
        o_entry.speech_frames    = speech1;
        o_entry.total_frames     = vass_pkg::FIELD_W'(nxt);
    end

    always_comb begin
        n_in_seg = r_in_seg;
        n_any    = r_any;
        n_start  = r_start;
        n_end    = r_end;
        n_frame  = r_frame;
        n_kept   = r_kept;
        n_sil    = r_sil;
        n_speech = r_speech;
        if (accept) begin
            if (i_final_frame) begin
                n_in_seg = 1'b0;
                n_any    = 1'b0;
                n_start  = '0;
                n_end    = '0;
                n_frame  = '0;
                n_kept   = '0;
                n_sil    = '0;
                n_speech = '0;
            end else begin
                n_in_seg = cand_open && !do_close;
                n_any    = any1;
                n_start  = seg_start_c;
                n_end    = seg_end_c;
                n_frame  = nxt;
                n_kept   = kept1;
                n_sil    = sil1;
                n_speech = speech1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_gap <= vass_pkg::MAX_GAP_RESET;
            r_min_len <= vass_pkg::MIN_LEN_RESET;
            r_in_seg  <= 1'b0;
            r_any     <= 1'b0;
            r_start   <= '0;
            r_end     <= '0;
            r_frame   <= '0;
            r_kept    <= '0;
            r_sil     <= '0;
            r_speech  <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    vass_pkg::CFG_MAX_GAP: r_max_gap <= i_cfg_data;
                    vass_pkg::CFG_MIN_LEN: r_min_len <= i_cfg_data;
                    default: ;
                endcase
            end
            r_in_seg <= n_in_seg;
            r_any    <= n_any;
            r_start  <= n_start;
            r_end    <= n_end;
            r_frame  <= n_frame;
            r_kept   <= n_kept;
            r_sil    <= n_sil;
            r_speech <= n_speech;
        end
    end

endmodule

// ===== rtl/vass_queue.sv =====
// Short queue of result entries between the front and back ends.
module vass_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  vass_pkg::t_entry i_entry,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_not_empty,
    output vass_pkg::t_entry o_head
);

    localparam int DEPTH = vass_pkg::QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);

    vass_pkg::t_entry r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [AW:0]      r_count;

    assign o_full      = (r_count == (AW+1)'(DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_head      = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/vass_back.sv =====
// Back end: splits queue entries into result items and holds the output register.
module vass_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_not_empty,
    input  vass_pkg::t_entry              i_head,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_kind,
    output logic [vass_pkg::FIELD_W-1:0]  o_seg_start,
    output logic [vass_pkg::FIELD_W-1:0]  o_seg_end,
    output logic [vass_pkg::FIELD_W-1:0]  o_speech_segments,
    output logic [vass_pkg::FIELD_W-1:0]  o_silence_segments,
    output logic [vass_pkg::FIELD_W-1:0]  o_speech_frames,
    output logic [vass_pkg::FIELD_W-1:0]  o_total_frames,
    output logic                          o_last
);

    vass_pkg::t_phase r_phase, n_phase;
    logic             load, emit_rec;

    assign load = i_not_empty && (!o_valid || i_ready);

    always_comb begin
        n_phase = r_phase;
        if (load) begin
            if (emit_rec && i_head.sum_ok) begin
                n_phase = vass_pkg::PH_SECOND;
            end else begin
                n_phase = vass_pkg::PH_FIRST;
            end
        end
    end

    always_comb begin
        emit_rec = i_head.rec_ok && (r_phase == vass_pkg::PH_FIRST);
        o_pop    = load && !(emit_rec && i_head.sum_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= vass_pkg::PH_FIRST;
            o_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            if (load) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (emit_rec) begin
                o_kind             <= vass_pkg::KIND_RECORD;
                o_seg_start        <= i_head.seg_start;
                o_seg_end          <= i_head.seg_end;
                o_speech_segments  <= '0;
                o_silence_segments <= '0;
                o_speech_frames    <= '0;
                o_total_frames     <= '0;
                o_last             <= 1'b0;
            end else begin
                o_kind             <= vass_pkg::KIND_SUMMARY;
                o_seg_start        <= '0;
                o_seg_end          <= '0;
                o_speech_segments  <= i_head.speech_segments;
                o_silence_segments <= i_head.silence_segments;
                o_speech_frames    <= i_head.speech_frames;
                o_total_frames     <= i_head.total_frames;
                o_last             <= 1'b1;
            end
        end
    end

endmodule

// ===== rtl/voice_activity_segment_smoother.sv =====
// Top level of the voice activity segment smoother.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-----------------------------------------
//  frames   | i_valid / o_ready       | i_frame_active, i_final_frame
//  results  | o_valid / i_ready       | o_kind, o_seg_*, summary counts, o_last
//  config   | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// One frame is taken per cycle while the queue is not full. Results leave one
// per cycle from the output register while i_ready is high, so a final frame
// closing a kept segment yields a record, then a summary; the four-entry queue
// absorbs bursts. A frame producing no result never occupies the queue.
// Synchronous active-low reset; no clearing pass. Config is always ready.
module voice_activity_segment_smoother #(
    parameter int FRAME_INDEX_BITS = vass_pkg::FRAME_INDEX_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_frame_active,
    input  logic                           i_final_frame,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_kind,
    output logic [vass_pkg::FIELD_W-1:0]   o_seg_start,
    output logic [vass_pkg::FIELD_W-1:0]   o_seg_end,
    output logic [vass_pkg::FIELD_W-1:0]   o_speech_segments,
    output logic [vass_pkg::FIELD_W-1:0]   o_silence_segments,
    output logic [vass_pkg::FIELD_W-1:0]   o_speech_frames,
    output logic [vass_pkg::FIELD_W-1:0]   o_total_frames,
    output logic                           o_last,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [vass_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [vass_pkg::CFG_W-1:0]     i_cfg_data
);

    vass_pkg::t_entry push_entry, head_entry;
    logic             push, full, pop, not_empty;

    vass_front #(
        .FRAME_INDEX_BITS(FRAME_INDEX_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_frame_active (i_frame_active),
        .i_final_frame  (i_final_frame),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_full         (full),
        .o_push         (push),
        .o_entry        (push_entry)
    );

    vass_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_entry     (push_entry),
        .o_full      (full),
        .i_pop       (pop),
        .o_not_empty (not_empty),
        .o_head      (head_entry)
    );

    vass_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_not_empty        (not_empty),
        .i_head             (head_entry),
        .o_pop              (pop),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_kind             (o_kind),
        .o_seg_start        (o_seg_start),
        .o_seg_end          (o_seg_end),
        .o_speech_segments  (o_speech_segments),
        .o_silence_segments (o_silence_segments),
        .o_speech_frames    (o_speech_frames),
        .o_total_frames     (o_total_frames),
        .o_last             (o_last)
    );

endmodule

// ===== rtl/vass_checker.sv =====
// Port checker for the voice activity segment smoother, with its bind.
`include "voice_activity_segment_smoother_macros.svh"

module vass_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_valid,
    input logic                         i_ready,
    input logic                         o_kind,
    input logic [vass_pkg::FIELD_W-1:0] o_seg_start,
    input logic [vass_pkg::FIELD_W-1:0] o_seg_end,
    input logic [vass_pkg::FIELD_W-1:0] o_speech_segments,
    input logic [vass_pkg::FIELD_W-1:0] o_silence_segments,
    input logic [vass_pkg::FIELD_W-1:0] o_speech_frames,
    input logic [vass_pkg::FIELD_W-1:0] o_total_frames,
    input logic                         o_last
);

    logic [6*vass_pkg::FIELD_W+1:0] out_word;
    logic                           is_summary;
    logic                           counts_clear;
    logic                           span_clear;

    assign out_word     = {o_kind, o_seg_start, o_seg_end, o_speech_segments,
                           o_silence_segments, o_speech_frames, o_total_frames, o_last};
    assign is_summary   = (o_kind == vass_pkg::KIND_SUMMARY);
    assign counts_clear = (o_speech_segments == '0) && (o_silence_segments == '0)
                       && (o_speech_frames == '0) && (o_total_frames == '0);
    assign span_clear   = (o_seg_start == '0) && (o_seg_end == '0);

    `VASS_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(out_word))
    `VASS_ASSERT_ALWAYS(a_last_is_summary, !o_valid || (o_last == is_summary))
    `VASS_ASSERT_ALWAYS(a_record_no_counts, !o_valid || is_summary || counts_clear)
    `VASS_ASSERT_ALWAYS(a_summary_no_span, !o_valid || !is_summary || span_clear)

endmodule

bind voice_activity_segment_smoother vass_checker u_vass_checker (.*);
